// ===== src/gfl_pkg.sv =====
// Shared types, codes and helpers for the grant reference free list allocator.
`default_nettype none

package gfl_pkg;

   // Link and field widths fixed by the interface.
   localparam int LINK_W = 13;
   localparam int REF_W = 12;
   localparam int MODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W = 4;
   localparam logic [LINK_W-1:0] LIST_END = 13'd4096;
   localparam int COUNT_MAX = 8191;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FREE_ONE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FREE_CHAIN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLAIM = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // Commands from the controller to the datapath, one per cycle.
   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_INIT_WR,
      CMD_LATCH,
      CMD_DISPATCH,
      CMD_G_STEP,
      CMD_G_SETUP,
      CMD_G_WR,
      CMD_A_START,
      CMD_RD,
      CMD_A_STEP,
      CMD_T_FIN,
      CMD_F_STEP,
      CMD_P_FIN
   } dp_cmd_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic              init_skip;
      logic              init_last;
      logic [MODE_W-1:0] mode;
      logic              count_zero;
      logic              count_one;
      logic              lhead_end;
      logic              need_grow;
      logic              grow_more;
      logic              grow_fail;
      logic              grow_last;
      logic              cnt_one;
      logic              walk_more;
   } dp_status_type;

   // Saturating count at the free count's largest value.
   function automatic logic [LINK_W-1:0] sat_count(input logic [31:0] s);
      logic [LINK_W-1:0] r;
      if (s > 32'(COUNT_MAX)) begin
         r = LINK_W'(COUNT_MAX);
      end else begin
         r = LINK_W'(s);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/gfl_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module gfl_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/gfl_ctrl.sv =====
// Controller state machine of the free list allocator.
`default_nettype none

module gfl_ctrl
   import gfl_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire dp_status_type st,
   output      dp_cmd_type    cmd,
   output      logic          busy,
   output      logic          rsp_valid
);

   typedef enum logic [15:0] {
      S_INIT     = 16'h0001,
      S_IDLE     = 16'h0002,
      S_DISPATCH = 16'h0004,
      S_G_CALC   = 16'h0008,
      S_G_SETUP  = 16'h0010,
      S_G_WR     = 16'h0020,
      S_A_START  = 16'h0040,
      S_A_RD     = 16'h0080,
      S_A_WT     = 16'h0100,
      S_T_RD     = 16'h0200,
      S_T_WT     = 16'h0400,
      S_F_RD     = 16'h0800,
      S_F_WT     = 16'h1000,
      S_P_RD     = 16'h2000,
      S_P_WT     = 16'h4000,
      S_DONE     = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and the command for the datapath.
   always_comb begin
      state_in = state_ff;
      cmd = CMD_NOP;
      case (state_ff)
         S_INIT: begin
            if (st.init_skip) begin
               state_in = S_IDLE;
            end else begin
               cmd = CMD_INIT_WR;
               if (st.init_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd = CMD_LATCH;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd = CMD_DISPATCH;
            state_in = S_DONE;
            if (st.mode == MODE_ALLOC && !st.count_zero) begin
               state_in = st.need_grow ? S_G_CALC : S_A_START;
            end else if (st.mode == MODE_FREE_CHAIN && !st.lhead_end) begin
               state_in = S_F_RD;
            end else if (st.mode == MODE_CLAIM && !st.lhead_end) begin
               state_in = S_P_RD;
            end
         end
         S_G_CALC: begin
            cmd = CMD_G_STEP;
            if (!st.grow_more) begin
               state_in = S_G_SETUP;
            end else if (st.grow_fail) begin
               state_in = S_DONE;
            end
         end
         S_G_SETUP: begin
            cmd = CMD_G_SETUP;
            state_in = S_G_WR;
         end
         S_G_WR: begin
            cmd = CMD_G_WR;
            if (st.grow_last) begin
               state_in = S_A_START;
            end
         end
         S_A_START: begin
            cmd = CMD_A_START;
            state_in = st.count_one ? S_T_RD : S_A_RD;
         end
         S_A_RD: begin
            cmd = CMD_RD;
            state_in = S_A_WT;
         end
         S_A_WT: begin
            cmd = CMD_A_STEP;
            state_in = st.cnt_one ? S_T_RD : S_A_RD;
         end
         S_T_RD: begin
            cmd = CMD_RD;
            state_in = S_T_WT;
         end
         S_T_WT: begin
            cmd = CMD_T_FIN;
            state_in = S_DONE;
         end
         S_F_RD: begin
            cmd = CMD_RD;
            state_in = S_F_WT;
         end
         S_F_WT: begin
            cmd = CMD_F_STEP;
            state_in = st.walk_more ? S_F_RD : S_DONE;
         end
         S_P_RD: begin
            cmd = CMD_RD;
            state_in = S_P_WT;
         end
         S_P_WT: begin
            cmd = CMD_P_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

`default_nettype wire

// ===== src/gfl_dp.sv =====
// Datapath of the free list allocator: list registers, walk pointer and link memory.
`default_nettype none

module gfl_dp
   import gfl_pkg::*;
#(
   parameter int ENTRIES_PER_FRAME = 512,
   parameter int MAX_FRAMES = 8,
   parameter int RESERVED_ENTRIES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [LINK_W-1:0]   req_count,
   input  wire logic [REF_W-1:0]    req_ref_req,
   input  wire logic [LINK_W-1:0]   req_list_head,
   input  wire logic                csr_wr_en,
   input  wire logic [LIMIT_W-1:0]  csr_wr_data,
   output      dp_status_type       st,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [LINK_W-1:0]   rsp_ref_out,
   output      logic [LINK_W-1:0]   rsp_new_head,
   output      logic [LINK_W-1:0]   rsp_free_count
);

   localparam int TS = ENTRIES_PER_FRAME * MAX_FRAMES;
   localparam int AW = $clog2(TS);
   localparam int FW = $clog2(MAX_FRAMES + 1);
   localparam int SW = $clog2(TS + 1);
   localparam int CW = (SW > LINK_W) ? SW : LINK_W;
   localparam int ACC_W = $clog2(COUNT_MAX + 1 + ENTRIES_PER_FRAME);
   localparam bit INIT_SKIP = (RESERVED_ENTRIES >= ENTRIES_PER_FRAME);
   localparam logic [LINK_W-1:0] HEAD_RESET =
      INIT_SKIP ? LIST_END : LINK_W'(RESERVED_ENTRIES);
   localparam logic [LINK_W-1:0] TOTAL_RESET =
      INIT_SKIP ? '0 : LINK_W'(ENTRIES_PER_FRAME - RESERVED_ENTRIES);

   // Control registers.
   logic [LIMIT_W-1:0] frame_limit_ff;
   logic [LINK_W-1:0]  free_head_ff, free_head_in;
   logic [LINK_W-1:0]  free_total_ff, free_total_in;
   logic [FW-1:0]      frames_used_ff, frames_used_in;
   logic [AW-1:0]      gi_ff, gi_in;

   // Per item working registers.
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [LINK_W-1:0]   count_ff, count_in;
   logic [REF_W-1:0]    ref_ff, ref_in;
   logic [LINK_W-1:0]   lhead_ff, lhead_in;
   logic [LINK_W-1:0]   ptr_ff, ptr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [FW-1:0]       extra_ff, extra_in;
   logic [AW-1:0]       glast_ff, glast_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LINK_W-1:0]   ref_out_ff, ref_out_in;
   logic [LINK_W-1:0]   new_head_ff, new_head_in;

   // Link memory ports.
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic [LINK_W-1:0] rd_data;

   logic              ptr_oob;
   logic [LINK_W-1:0] link;
   logic              ref_ok;
   logic [31:0]       first_frame_entry;

   gfl_ram #(
      .WIDTH(LINK_W),
      .DEPTH(TS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(AW'(ptr_ff)),
      .rd_data(rd_data)
   );

   // The pointer is steady from the read cycle to the use of the read data.
   assign ptr_oob = (32'(ptr_ff) >= 32'(TS));
   assign link = ptr_oob ? LIST_END : rd_data;
   assign ref_ok = (32'(ref_ff) < 32'(TS));
   assign first_frame_entry = 32'(frames_used_ff) * 32'(ENTRIES_PER_FRAME);

   // Status for the controller.
   always_comb begin
      st.init_skip = INIT_SKIP;
      st.init_last = (32'(gi_ff) == 32'(ENTRIES_PER_FRAME - 1));
      st.mode = mode_ff;
      st.count_zero = (count_ff == '0);
      st.count_one = (count_ff == LINK_W'(1));
      st.lhead_end = (lhead_ff == LIST_END);
      st.need_grow = (free_total_ff < count_ff);
      st.grow_more = (acc_ff < ACC_W'(count_ff));
      st.grow_fail = (32'(frames_used_ff) + 32'(extra_ff) + 32'd1 > 32'(frame_limit_ff))
                     || (32'(frames_used_ff) + 32'(extra_ff) + 32'd1 > 32'(MAX_FRAMES));
      st.grow_last = (gi_ff == glast_ff);
      st.cnt_one = (cnt_ff == CW'(1));
      st.walk_more = (link != LIST_END) && (32'(cnt_ff) < 32'(TS));
   end

   // Link memory writes.
   always_comb begin
      wr_en = 1'b0;
      wr_addr = gi_ff;
      wr_data = LINK_W'(32'(gi_ff) + 32'd1);
      case (cmd)
         CMD_INIT_WR: begin
            wr_en = 1'b1;
            if (st.init_last) begin
               wr_data = LIST_END;
            end
         end
         CMD_G_WR: begin
            wr_en = 1'b1;
            if (st.grow_last) begin
               wr_data = free_head_ff;
            end
         end
         CMD_DISPATCH: begin
            wr_addr = AW'(ref_ff);
            if (mode_ff == MODE_FREE_ONE) begin
               wr_en = ref_ok;
               wr_data = free_head_ff;
            end else if (mode_ff == MODE_RELEASE) begin
               wr_en = ref_ok;
               wr_data = lhead_ff;
            end
         end
         CMD_T_FIN: begin
            wr_en = !ptr_oob;
            wr_addr = AW'(ptr_ff);
            wr_data = LIST_END;
         end
         CMD_F_STEP: begin
            wr_en = !st.walk_more && !ptr_oob;
            wr_addr = AW'(ptr_ff);
            wr_data = free_head_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Register next values by command.
   always_comb begin
      free_head_in = free_head_ff;
      free_total_in = free_total_ff;
      frames_used_in = frames_used_ff;
      gi_in = gi_ff;
      mode_in = mode_ff;
      count_in = count_ff;
      ref_in = ref_ff;
      lhead_in = lhead_ff;
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      extra_in = extra_ff;
      glast_in = glast_ff;
      status_in = status_ff;
      ref_out_in = ref_out_ff;
      new_head_in = new_head_ff;
      case (cmd)
         CMD_INIT_WR: begin
            gi_in = gi_ff + AW'(1);
         end
         CMD_LATCH: begin
            mode_in = req_mode;
            count_in = req_count;
            ref_in = req_ref_req;
            lhead_in = (32'(req_list_head) >= 32'(TS)) ? LIST_END : req_list_head;
            status_in = ST_OK;
            ref_out_in = LIST_END;
            new_head_in = LIST_END;
         end
         CMD_DISPATCH: begin
            ptr_in = lhead_ff;
            cnt_in = '0;
            acc_in = ACC_W'(free_total_ff);
            extra_in = '0;
            if (mode_ff == MODE_FREE_ONE && ref_ok) begin
               free_head_in = LINK_W'(ref_ff);
               free_total_in = sat_count(32'(free_total_ff) + 32'd1);
            end else if (mode_ff == MODE_CLAIM) begin
               if (lhead_ff == LIST_END) begin
                  status_in = ST_EMPTY;
               end else begin
                  ref_out_in = lhead_ff;
               end
            end else if (mode_ff == MODE_RELEASE) begin
               new_head_in = ref_ok ? LINK_W'(ref_ff) : lhead_ff;
            end
         end
         CMD_G_STEP: begin
            if (st.grow_more) begin
               if (st.grow_fail) begin
                  status_in = ST_NOSPACE;
               end else begin
                  acc_in = acc_ff + ACC_W'(ENTRIES_PER_FRAME);
                  extra_in = extra_ff + FW'(1);
               end
            end
         end
         CMD_G_SETUP: begin
            gi_in = AW'(first_frame_entry);
            glast_in = AW'((32'(frames_used_ff) + 32'(extra_ff))
                           * 32'(ENTRIES_PER_FRAME) - 32'd1);
         end
         CMD_G_WR: begin
            gi_in = gi_ff + AW'(1);
            if (st.grow_last) begin
               free_head_in = LINK_W'(first_frame_entry);
               free_total_in = sat_count(32'(free_total_ff)
                                         + 32'(extra_ff) * 32'(ENTRIES_PER_FRAME));
               frames_used_in = frames_used_ff + extra_ff;
            end
         end
         CMD_A_START: begin
            ref_out_in = free_head_ff;
            free_total_in = free_total_ff - count_ff;
            ptr_in = free_head_ff;
            cnt_in = CW'(count_ff) - CW'(1);
         end
         CMD_A_STEP: begin
            ptr_in = link;
            cnt_in = cnt_ff - CW'(1);
         end
         CMD_T_FIN: begin
            free_head_in = link;
         end
         CMD_F_STEP: begin
            if (st.walk_more) begin
               ptr_in = link;
               cnt_in = cnt_ff + CW'(1);
            end else begin
               free_head_in = lhead_ff;
               free_total_in = sat_count(32'(free_total_ff) + 32'(cnt_ff) + 32'd1);
            end
         end
         CMD_P_FIN: begin
            new_head_in = link;
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= LIMIT_RESET;
         free_head_ff <= HEAD_RESET;
         free_total_ff <= TOTAL_RESET;
         frames_used_ff <= FW'(1);
         gi_ff <= AW'(RESERVED_ENTRIES);
      end else begin
         if (csr_wr_en) begin
            frame_limit_ff <= csr_wr_data;
         end
         free_head_ff <= free_head_in;
         free_total_ff <= free_total_in;
         frames_used_ff <= frames_used_in;
         gi_ff <= gi_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      count_ff <= count_in;
      ref_ff <= ref_in;
      lhead_ff <= lhead_in;
      ptr_ff <= ptr_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      extra_ff <= extra_in;
      glast_ff <= glast_in;
      status_ff <= status_in;
      ref_out_ff <= ref_out_in;
      new_head_ff <= new_head_in;
   end

   assign rsp_status = status_ff;
   assign rsp_ref_out = ref_out_ff;
   assign rsp_new_head = new_head_ff;
   assign rsp_free_count = free_total_ff;

endmodule

`default_nettype wire

// ===== src/grant_ref_free_list_allocator.sv =====
// Top level of the grant reference free list allocator.
`default_nettype none

// Reference number allocator with its free list kept as next-links in one
// link memory. Pulse start while busy is low to issue one command; the
// result comes back on the rsp_ ports for one cycle with rsp_valid and
// cannot be held off. After reset the block runs a setup pass that chains
// frame 0 with busy high. Each link read goes through the registered read
// port of the link memory, in a read state and then a wait state. An
// allocation of count entries walks count links from the free head, a chain
// free walks the chain to its tail, and a claim reads one link. Growth adds
// whole frames one at a time, then writes one link per new entry. The
// frame limit register may be written only while busy is low.
module grant_ref_free_list_allocator
   import gfl_pkg::*;
#(
   parameter int ENTRIES_PER_FRAME = 512,
   parameter int MAX_FRAMES = 8,
   parameter int RESERVED_ENTRIES = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [LINK_W-1:0]   req_count,
   input  wire logic [REF_W-1:0]    req_ref_req,
   input  wire logic [LINK_W-1:0]   req_list_head,
   output      logic                rsp_valid,
   output      logic [STATUS_W-1:0] rsp_status,
   output      logic [LINK_W-1:0]   rsp_ref_out,
   output      logic [LINK_W-1:0]   rsp_new_head,
   output      logic [LINK_W-1:0]   rsp_free_count,
   input  wire logic                csr_wr_en,
   input  wire logic [LIMIT_W-1:0]  csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type st;

   gfl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .st       (st),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   gfl_dp #(
      .ENTRIES_PER_FRAME(ENTRIES_PER_FRAME),
      .MAX_FRAMES       (MAX_FRAMES),
      .RESERVED_ENTRIES (RESERVED_ENTRIES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_mode      (req_mode),
      .req_count     (req_count),
      .req_ref_req   (req_ref_req),
      .req_list_head (req_list_head),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .st            (st),
      .rsp_status    (rsp_status),
      .rsp_ref_out   (rsp_ref_out),
      .rsp_new_head  (rsp_new_head),
      .rsp_free_count(rsp_free_count)
   );

   // A result beat only ever closes a command that was in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat without a command in progress");

   // One result beat per command.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   // An accepted command makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command did not raise busy");

   // A no space answer carries no entry and no private head.
   a_nospace_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOSPACE |->
         rsp_ref_out == LIST_END && rsp_new_head == LIST_END)
      else $error("no space answer carries an entry");

endmodule

`default_nettype wire

// ===== dv/gfl_checker.sv =====
// Checker for the free list allocator: predicts each command's response and compares it.
`default_nettype none

module gfl_checker
   import gfl_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                busy,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [LINK_W-1:0]   req_count,
   input  wire logic [REF_W-1:0]    req_ref_req,
   input  wire logic [LINK_W-1:0]   req_list_head,
   input  wire logic                rsp_valid,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic [LINK_W-1:0]   rsp_ref_out,
   input  wire logic [LINK_W-1:0]   rsp_new_head,
   input  wire logic [LINK_W-1:0]   rsp_free_count,
   input  wire logic                csr_wr_en,
   input  wire logic [LIMIT_W-1:0]  csr_wr_data,
   output      int unsigned         errors,
   output      int unsigned         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAME_SZ = 512;
   localparam int unsigned FRAME_MAX = 8;
   localparam int unsigned RSVD = 8;
   localparam int unsigned TBL = FRAME_SZ * FRAME_MAX;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LINK_W-1:0]   ref_out;
      logic [LINK_W-1:0]   new_head;
      logic [LINK_W-1:0]   free_count;
   } alloc_beat_type;

   // Shadow copy of the allocator state.
   logic [LINK_W-1:0] link_mem [TBL];
   int unsigned       free_head;
   int unsigned       free_total;
   int unsigned       frames_used;
   logic [LIMIT_W-1:0] frame_limit;
   alloc_beat_type    expected_q[$];
   int unsigned       fail_cnt = 0;

   assign errors = fail_cnt;

   function automatic int unsigned link_at(input int unsigned i);
      return (i >= TBL) ? int'(LIST_END) : int'(link_mem[i]);
   endfunction

   task automatic link_set(input int unsigned i, input int unsigned v);
      if (i < TBL) begin
         link_mem[i] = LINK_W'(v);
      end
   endtask

   task automatic add_free(input int unsigned n);
      free_total = (free_total + n > COUNT_MAX) ? COUNT_MAX : free_total + n;
   endtask

   task automatic clear_state();
      for (int unsigned i = RSVD; i + 1 < FRAME_SZ; i++) begin
         link_mem[i] = LINK_W'(i + 1);
      end
      link_mem[FRAME_SZ-1] = LIST_END;
      free_head = RSVD;
      free_total = FRAME_SZ - RSVD;
      frames_used = 1;
      frame_limit = LIMIT_RESET;
   endtask

   // Work out one command's response and update the shadow state.
   task automatic predict_beat(output alloc_beat_type r);
      int unsigned cnt;
      int unsigned lhead;
      int unsigned lim;
      int unsigned extra;
      int unsigned first;
      int unsigned last;
      int unsigned h;
      int unsigned n;
      int unsigned steps;
      bit ok;
      cnt = req_count;
      lhead = (req_list_head >= TBL) ? int'(LIST_END) : int'(req_list_head);
      r.status = ST_OK;
      r.ref_out = LIST_END;
      r.new_head = LIST_END;
      if (req_mode == MODE_ALLOC && cnt != 0) begin
         ok = 1;
         // Grow by whole frames in front of the head when short of entries.
         if (free_total < cnt) begin
            lim = (frame_limit < FRAME_MAX) ? frame_limit : FRAME_MAX;
            extra = (cnt - free_total + FRAME_SZ - 1) / FRAME_SZ;
            if (frames_used + extra > lim) begin
               ok = 0;
            end else begin
               first = FRAME_SZ * frames_used;
               last = FRAME_SZ * (frames_used + extra) - 1;
               for (int unsigned i = first; i < last; i++) begin
                  link_set(i, i + 1);
               end
               link_set(last, free_head);
               free_head = first;
               add_free(extra * FRAME_SZ);
               frames_used += extra;
            end
         end
         if (!ok) begin
            r.status = ST_NOSPACE;
         end else begin
            h = free_head;
            r.ref_out = LINK_W'(h);
            free_total -= cnt;
            for (int unsigned k = 1; k < cnt; k++) begin
               h = link_at(h);
            end
            free_head = link_at(h);
            link_set(h, LIST_END);
         end
      end else if (req_mode == MODE_FREE_ONE) begin
         link_set(req_ref_req, free_head);
         free_head = req_ref_req;
         add_free(1);
      end else if (req_mode == MODE_FREE_CHAIN) begin
         // Walk to the tail, bounded so a cyclic chain still ends.
         if (lhead != LIST_END) begin
            h = lhead;
            n = 1;
            steps = 0;
            while (link_at(h) != LIST_END && steps < TBL) begin
               h = link_at(h);
               n++;
               steps++;
            end
            link_set(h, free_head);
            free_head = lhead;
            add_free(n);
         end
      end else if (req_mode == MODE_CLAIM) begin
         if (lhead == LIST_END) begin
            r.status = ST_EMPTY;
         end else begin
            r.ref_out = LINK_W'(lhead);
            r.new_head = LINK_W'(link_at(lhead));
         end
      end else if (req_mode == MODE_RELEASE) begin
         link_set(req_ref_req, lhead);
         r.new_head = LINK_W'(req_ref_req);
      end
      r.free_count = LINK_W'(free_total);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         fail_cnt++;
      end
   endtask

   // Compare response beats first, then record new commands and writes.
   always @(posedge clock) begin
      alloc_beat_type want;
      if (reset) begin
         clear_state();
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response beat with nothing expected", $realtime);
               fail_cnt++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("ref_out", want.ref_out, rsp_ref_out);
               check_field("new_head", want.new_head, rsp_new_head);
               check_field("free_count", want.free_count, rsp_free_count);
            end
         end
         if (start && !busy) begin
            predict_beat(want);
            expected_q.push_back(want);
         end
         if (csr_wr_en) begin
            frame_limit = csr_wr_data;
         end
      end
      pending = expected_q.size();
   end

endmodule

`default_nettype wire

// ===== dv/grant_ref_free_list_allocator_test.sv =====
// Stimulus and verdict for the free list allocator testbench.
`default_nettype none

module grant_ref_free_list_allocator_test;
   import gfl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode = MODE_ALLOC;
   logic [LINK_W-1:0]   req_count = '0;
   logic [REF_W-1:0]    req_ref_req = '0;
   logic [LINK_W-1:0]   req_list_head = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [LINK_W-1:0]   rsp_ref_out;
   logic [LINK_W-1:0]   rsp_new_head;
   logic [LINK_W-1:0]   rsp_free_count;
   logic                csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]  csr_wr_data = '0;
   int unsigned         errors;
   int unsigned         pending;

   // Entries whose link is known to be written, so chain walks stay legal.
   bit                  link_known [4096];
   logic [LINK_W-1:0]   chain_heads[$];
   logic [MODE_W-1:0]   mode_q[$];
   logic [LINK_W-1:0]   priv_head = LIST_END;
   int unsigned         idle_pct = 0;

   always #5 clock = ~clock;

   grant_ref_free_list_allocator u_top (
      .clock, .reset, .start, .busy,
      .req_mode, .req_count, .req_ref_req, .req_list_head,
      .rsp_valid, .rsp_status, .rsp_ref_out, .rsp_new_head, .rsp_free_count,
      .csr_wr_en, .csr_wr_data
   );

   gfl_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_mode, .req_count, .req_ref_req, .req_list_head,
      .rsp_valid, .rsp_status, .rsp_ref_out, .rsp_new_head, .rsp_free_count,
      .csr_wr_en, .csr_wr_data, .errors, .pending
   );

   // Learn written entries, chain heads and the private head from responses.
   always @(posedge clock) begin
      logic [MODE_W-1:0] m;
      if (!reset && rsp_valid && mode_q.size() != 0) begin
         m = mode_q.pop_front();
         if (rsp_ref_out < LIST_END) begin
            link_known[rsp_ref_out[REF_W-1:0]] = 1;
            if (rsp_status == ST_OK && chain_heads.size() < 64) begin
               chain_heads.push_back(rsp_ref_out);
            end
         end
         if (rsp_new_head < LIST_END) begin
            link_known[rsp_new_head[REF_W-1:0]] = 1;
         end
         if (m == MODE_CLAIM || m == MODE_RELEASE) begin
            priv_head = rsp_new_head;
         end
      end
   end

   // Issue one command beat once busy is low, after an optional gap.
   task automatic send(input logic [MODE_W-1:0] m, input int unsigned cnt,
                       input int unsigned rf, input int unsigned lh);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
      end
      @(negedge clock);
      while (busy !== 1'b0) begin
         @(negedge clock);
      end
      start <= 1'b1;
      req_mode <= m;
      req_count <= LINK_W'(cnt);
      req_ref_req <= REF_W'(rf);
      req_list_head <= LINK_W'(lh);
      mode_q.push_back(m);
      if (m == MODE_FREE_ONE || m == MODE_RELEASE) begin
         link_known[rf[REF_W-1:0]] = 1;
      end
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending != 0 || busy !== 1'b0) begin
         @(negedge clock);
      end
   endtask

   task automatic set_limit(input logic [LIMIT_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int unsigned known_entry();
      int unsigned idx;
      do begin
         idx = $urandom_range(4095);
      end while (!link_known[idx]);
      return idx;
   endfunction

   function automatic int unsigned pick_count();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 85) begin
         return $urandom_range(8, 1);
      end else if (r < 97) begin
         return $urandom_range(64, 9);
      end
      return $urandom_range(1200, 100);
   endfunction

   // Mostly well-formed traffic on real chains, with some noise.
   task automatic random_beat();
      int unsigned r;
      int unsigned lh;
      r = $urandom_range(99);
      if (r < 35) begin
         send(MODE_ALLOC, pick_count(), $urandom, $urandom);
      end else if (r < 55) begin
         lh = (chain_heads.size() != 0) ? chain_heads.pop_front() : LIST_END;
         send(MODE_FREE_CHAIN, $urandom, $urandom, lh);
      end else if (r < 65) begin
         send(MODE_FREE_ONE, $urandom, $urandom_range(4095), $urandom);
      end else if (r < 80) begin
         send(MODE_RELEASE, $urandom, $urandom_range(4095), priv_head);
      end else if (r < 90) begin
         send(MODE_CLAIM, $urandom, $urandom, priv_head);
      end else if (r < 95) begin
         // Unused modes, or list heads outside the table.
         if ($urandom_range(1)) begin
            send(MODE_W'($urandom_range(7, 5)), $urandom, $urandom, $urandom);
         end else begin
            send(MODE_W'($urandom_range(4, 2)), $urandom, $urandom,
                 $urandom_range(8191, 4096));
         end
      end else begin
         send(MODE_W'($urandom_range(3, 2)), $urandom, $urandom, known_entry());
      end
   endtask

   initial begin
      for (int i = 8; i < 512; i++) begin
         link_known[i] = 1;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed corners at the reset frame limit.
      send(MODE_ALLOC, 0, 0, 0);
      send(MODE_ALLOC, 1, 0, 0);
      send(MODE_ALLOC, 4096, 4095, 8191);
      send(3'd5, 8191, 4095, 8191);
      send(3'd6, 0, 0, 0);
      send(3'd7, 1, 1, 1);
      send(MODE_FREE_CHAIN, 0, 0, LIST_END);
      send(MODE_FREE_CHAIN, 0, 0, 8191);
      send(MODE_CLAIM, 0, 0, LIST_END);
      send(MODE_CLAIM, 0, 0, 5000);
      send(MODE_RELEASE, 0, 4095, LIST_END);
      send(MODE_CLAIM, 0, 0, 4095);
      send(MODE_RELEASE, 0, 0, 6000);
      send(MODE_ALLOC, 600, 0, 0);
      send(MODE_ALLOC, 1200, 0, 0);
      send(MODE_ALLOC, 2000, 0, 0);
      drain();
      while (chain_heads.size() != 0) begin
         send(MODE_FREE_CHAIN, 0, 0, chain_heads.pop_front());
      end

      // A self-linked entry makes a cyclic chain; two walks saturate the count.
      set_limit(4'd8);
      send(MODE_FREE_ONE, 0, 100, 0);
      send(MODE_FREE_ONE, 0, 100, 0);
      send(MODE_FREE_CHAIN, 0, 0, 100);
      send(MODE_FREE_CHAIN, 0, 0, 100);
      send(MODE_ALLOC, 4095, 0, 0);
      send(MODE_ALLOC, 4095, 0, 0);
      send(MODE_ALLOC, 1, 0, 0);
      send(MODE_ALLOC, 2, 0, 0);

      // Random phases with different gap rates and frame limits.
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 31 : (ph == 1) ? 74 : 0;
         set_limit((ph == 0) ? 4'd2 : (ph == 1) ? 4'd15 : 4'd1);
         for (int i = 0; i < 230; i++) begin
            if (ph == 0 && i == 100) begin
               drain();
            end
            random_beat();
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #300ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
src/gfl_pkg.sv
src/gfl_ram.sv
src/gfl_ctrl.sv
src/gfl_dp.sv
src/grant_ref_free_list_allocator.sv
dv/gfl_checker.sv
dv/grant_ref_free_list_allocator_test.sv
